FILE: sv/rdrp_pkg.sv
// Shared types, constants and codes of the ragged-to-dense run planner.
// Depends on nothing; every other file of the block imports it.
package rdrp_pkg;

	// Dense shape limits.
	localparam int MAX_DIMS     = 4;
	localparam int LVL_W        = $clog2(MAX_DIMS + 1);
	localparam int DIM_IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// Field widths.
	localparam int LEN_W      = 12;
	localparam int CNT_W      = 13;
	localparam int OFF_W      = 48;
	localparam int PROD_W     = OFF_W + LEN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int NDIM_W     = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Queue depths (powers of two).
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

	// Token kinds.
	localparam logic [1:0] FUNC_BEGIN   = 2'd0;
	localparam logic [1:0] FUNC_FINISH  = 2'd1;
	localparam logic [1:0] FUNC_COUNT   = 2'd2;
	localparam logic [1:0] FUNC_RESTART = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_COPY  = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Commands from the front part to the back part.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ERROR = 2'd1,
		CMD_INNER = 2'd2,
		CMD_OUTER = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [LEN_W-1:0]   count;
		logic [LEN_W-1:0]   length;
		logic [LEN_W-1:0]   missing;
		logic [OFF_W-1:0]   product;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [1:0]       kind;
		logic [OFF_W-1:0] offset;
		logic [OFF_W-1:0] length;
		logic             last;
	} result_t;

	// Configuration as seen by the front part.
	typedef struct packed {
		logic                             busy;
		logic [LVL_W-1:0]                 eff_dims;
		logic [MAX_DIMS-1:0][LEN_W-1:0]   dim_len;
		logic [MAX_DIMS:0][OFF_W-1:0]     block_prod;
	} cfg_t;

endpackage

FILE: sv/rdrp_config.sv
// Configuration registers and the block product sequencer of the run planner.
// Depends on rdrp_pkg.
module rdrp_config
	import rdrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	typedef enum logic [2:0] {
		SEQ_IDLE  = 3'b001,
		SEQ_START = 3'b010,
		SEQ_STEP  = 3'b100
	} seq_state_t;

	seq_state_t                     state_q;
	logic [NDIM_W-1:0]              num_dims_q;
	logic [MAX_DIMS-1:0][LEN_W-1:0] dim_len_q;
	logic [MAX_DIMS:0][OFF_W-1:0]   block_prod_q;
	logic [LVL_W-1:0]               idx_q;
	logic [LVL_W-1:0]               idx_m1;
	logic [LVL_W-1:0]               eff_dims;
	logic [CFG_IDX_W-1:0]           dim_sel;
	logic                           wr_en;
	logic                           wr_known;
	logic [PROD_W-1:0]              prod_full;

	// Clamp the dimension count to the supported range.
	always_comb begin
		if (num_dims_q == '0) begin
			eff_dims = LVL_W'(1);
		end else if (int'(num_dims_q) > MAX_DIMS) begin
			eff_dims = LVL_W'(MAX_DIMS);
		end else begin
			eff_dims = LVL_W'(num_dims_q);
		end
	end

	// Writes are taken only while no rebuild is running.
	assign cfg_ready = (state_q == SEQ_IDLE);
	assign wr_en     = cfg_valid && cfg_ready;
	assign wr_known  = (cfg_index <= REG_DIM_SIZE_3);
	assign dim_sel   = cfg_index - CFG_IDX_W'(1);

	// One product step per cycle, innermost level first.
	assign idx_m1    = idx_q - LVL_W'(1);
	assign prod_full = PROD_W'(dim_len_q[idx_m1[DIM_IDX_W-1:0]]) * PROD_W'(block_prod_q[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SEQ_IDLE;
			num_dims_q   <= NDIM_W'(1);
			dim_len_q    <= {MAX_DIMS{LEN_W'(1)}};
			block_prod_q <= {(MAX_DIMS + 1){OFF_W'(1)}};
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				SEQ_IDLE: begin
					if (wr_en && wr_known) begin
						if (cfg_index == REG_NUM_DIMS) begin
							num_dims_q <= cfg_data[NDIM_W-1:0];
						end else if (int'(dim_sel) < MAX_DIMS) begin
							dim_len_q[dim_sel[DIM_IDX_W-1:0]] <= cfg_data[LEN_W-1:0];
						end
						state_q <= SEQ_START;
					end
				end
				SEQ_START: begin
					block_prod_q <= {(MAX_DIMS + 1){OFF_W'(1)}};
					idx_q        <= eff_dims;
					state_q      <= SEQ_STEP;
				end
				SEQ_STEP: begin
					block_prod_q[idx_m1] <= prod_full[OFF_W-1:0];
					idx_q                <= idx_m1;
					if (idx_q == LVL_W'(1)) begin
						state_q <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	assign cfg.busy       = (state_q != SEQ_IDLE);
	assign cfg.eff_dims   = eff_dims;
	assign cfg.dim_len    = dim_len_q;
	assign cfg.block_prod = block_prod_q;

endmodule

FILE: sv/rdrp_front.sv
// Front part of the run planner: tracks nesting and turns tokens into commands.
// Depends on rdrp_pkg.
module rdrp_front
	import rdrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_take,
	input  logic [1:0]       func,
	input  logic [LEN_W-1:0] elem_count,
	input  cfg_t             cfg,
	output logic             cmd_push,
	output cmd_t             cmd
);

	logic [LVL_W-1:0]             lvl_q;
	logic [MAX_DIMS:0][CNT_W-1:0] counts_q;
	logic                         error_q;

	logic [LVL_W-1:0] lvl_m1;
	logic [CNT_W-1:0] cnt_cur;
	logic [LEN_W-1:0] len_cur;
	logic             is_inner;
	logic             raise_err;

	assign lvl_m1   = lvl_q - LVL_W'(1);
	assign cnt_cur  = counts_q[lvl_q];
	assign len_cur  = cfg.dim_len[lvl_m1[DIM_IDX_W-1:0]];
	assign is_inner = (lvl_q == cfg.eff_dims);

	// Classify the token: error, command for the back part, or state change only.
	always_comb begin
		raise_err   = 1'b0;
		cmd_push    = 1'b0;
		cmd.op      = CMD_CLEAR;
		cmd.count   = cnt_cur[LEN_W-1:0];
		cmd.length  = len_cur;
		cmd.missing = len_cur - cnt_cur[LEN_W-1:0];
		cmd.product = cfg.block_prod[lvl_q];
		if (func == FUNC_RESTART) begin
			cmd_push = in_take;
		end else if (!error_q) begin
			unique case (func)
				FUNC_BEGIN: begin
					raise_err = (lvl_q >= cfg.eff_dims);
				end
				FUNC_COUNT: begin
					raise_err = !is_inner;
				end
				FUNC_FINISH: begin
					if (lvl_q == '0 || lvl_q > cfg.eff_dims) begin
						raise_err = 1'b1;
					end else if (is_inner) begin
						if (cnt_cur > CNT_W'(len_cur)) begin
							raise_err = 1'b1;
						end else begin
							cmd.op   = CMD_INNER;
							cmd_push = in_take;
						end
					end else if (cnt_cur < CNT_W'(len_cur)) begin
						cmd.op   = CMD_OUTER;
						cmd_push = in_take;
					end
				end
				default: begin
					raise_err = 1'b0;
				end
			endcase
			if (raise_err) begin
				cmd.op   = CMD_ERROR;
				cmd_push = in_take;
			end
		end
	end

	// Nesting state update on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q    <= '0;
			counts_q <= '0;
			error_q  <= 1'b0;
		end else if (in_take) begin
			if (func == FUNC_RESTART) begin
				lvl_q    <= '0;
				counts_q <= '0;
				error_q  <= 1'b0;
			end else if (!error_q) begin
				if (raise_err) begin
					error_q <= 1'b1;
				end else begin
					case (func)
						FUNC_BEGIN: begin
							if (cnt_cur < COUNT_MAX) begin
								counts_q[lvl_q] <= cnt_cur + CNT_W'(1);
							end
							lvl_q <= lvl_q + LVL_W'(1);
						end
						FUNC_COUNT: begin
							counts_q[lvl_q] <= CNT_W'(elem_count);
						end
						FUNC_FINISH: begin
							counts_q[lvl_q] <= '0;
							lvl_q           <= lvl_m1;
						end
						default: begin
							lvl_q <= lvl_q;
						end
					endcase
				end
			end
		end
	end

endmodule

FILE: sv/rdrp_cmd_queue.sv
// Short command queue between the front and back parts of the run planner.
// Depends on rdrp_pkg.
module rdrp_cmd_queue
	import rdrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty,
	output logic full
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + CQ_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CQ_CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CQ_CNT_W'(1);
			end
		end
	end

endmodule

FILE: sv/rdrp_back.sv
// Back part of the run planner: keeps the dense offset and emits run results.
// Depends on rdrp_pkg; holds the result queue that drives the output ports.
module rdrp_back
	import rdrp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       run_kind,
	output logic [OFF_W-1:0] run_offset,
	output logic [OFF_W-1:0] run_length,
	output logic             last_of_run
);

	logic [OFF_W-1:0]    offset_q;
	logic                phase_q;
	logic [OFF_W-1:0]    delta_q;
	result_t             oq_mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	logic             out_take;
	logic             space;
	logic             has_copy;
	logic             has_fill;
	logic             res_push;
	result_t          res;
	logic             off_clear;
	logic             off_add;
	logic [OFF_W-1:0] off_inc;
	logic             mul_load;
	logic             phase_set;
	logic [PROD_W-1:0] mul_full;

	assign out_take = pop && !empty;
	assign space    = (oq_cnt_q != OQ_CNT_W'(OQ_DEPTH)) || out_take;
	assign has_copy = (cmd.count != '0);
	assign has_fill = (cmd.count < cmd.length);
	assign mul_full = PROD_W'(cmd.missing) * PROD_W'(cmd.product);

	// Carry out the head command, one result word per cycle while the result queue has room.
	always_comb begin
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res.kind   = KIND_FILL;
		res.offset = offset_q;
		res.length = '0;
		res.last   = 1'b1;
		off_clear  = 1'b0;
		off_add    = 1'b0;
		off_inc    = OFF_W'(cmd.length);
		mul_load   = 1'b0;
		phase_set  = 1'b0;
		if (cmd_valid) begin
			unique case (cmd.op)
				CMD_CLEAR: begin
					off_clear = 1'b1;
					cmd_pop   = 1'b1;
				end
				CMD_ERROR: begin
					res.kind = KIND_ERROR;
					res_push = space;
					cmd_pop  = space;
				end
				CMD_INNER: begin
					if (!phase_q && has_copy) begin
						res.kind   = KIND_COPY;
						res.length = OFF_W'(cmd.count);
						res.last   = !has_fill;
						res_push   = space;
						cmd_pop    = space && !has_fill;
						off_add    = space && !has_fill;
						phase_set  = space && has_fill;
					end else if (!has_fill) begin
						cmd_pop = 1'b1;
						off_add = 1'b1;
					end else begin
						res.offset = offset_q + OFF_W'(cmd.count);
						res.length = OFF_W'(cmd.length - cmd.count);
						res_push   = space;
						cmd_pop    = space;
						off_add    = space;
					end
				end
				CMD_OUTER: begin
					if (!phase_q) begin
						mul_load  = 1'b1;
						phase_set = 1'b1;
					end else begin
						res.length = delta_q;
						off_inc    = delta_q;
						res_push   = space;
						cmd_pop    = space;
						off_add    = space;
					end
				end
			endcase
		end
	end

	// Product register for short outer finishes.
	always_ff @(posedge clk) begin
		if (mul_load) begin
			delta_q <= mul_full[OFF_W-1:0];
		end
	end

	// Dense offset and command phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (off_clear) begin
				offset_q <= '0;
			end else if (off_add) begin
				offset_q <= offset_q + off_inc;
			end
			if (cmd_pop) begin
				phase_q <= 1'b0;
			end else if (phase_set) begin
				phase_q <= 1'b1;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (res_push) begin
			oq_mem_q[oq_wr_q] <= res;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (out_take) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (res_push && !out_take) begin
				oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
			end else if (out_take && !res_push) begin
				oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
			end
		end
	end

	assign empty       = (oq_cnt_q == '0);
	assign run_kind    = oq_mem_q[oq_rd_q].kind;
	assign run_offset  = oq_mem_q[oq_rd_q].offset;
	assign run_length  = oq_mem_q[oq_rd_q].length;
	assign last_of_run = oq_mem_q[oq_rd_q].last;

endmodule

FILE: sv/ragged_to_dense_run_planner.sv
// An innermost finish or an error shows its first result word after it has passed the command
// queue and the result queue; a short outer finish first loads the block-size product register.
// Throughput: one token per cycle in while full is low; the back end moves one result word per
// cycle while its result queue has room, and an innermost finish can give a copy and a fill word.
// A register write rebuilds the block sizes: a start state, then one step per dimension in use.
// Reset is asynchronous: registers return to one dimension of length one, state is cleared.
module ragged_to_dense_run_planner
	import rdrp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            func,
	input  logic [LEN_W-1:0]      elem_count,
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            run_kind,
	output logic [OFF_W-1:0]      run_offset,
	output logic [OFF_W-1:0]      run_length,
	output logic                  last_of_run,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	logic in_take;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cq_empty;
	logic cq_full;
	logic cmd_pop;

	// Tokens are held off while the queue is full or block sizes are rebuilt.
	assign full    = cq_full || cfg.busy;
	assign in_take = push && !full;

	rdrp_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rdrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_take),
		.func       (func),
		.elem_count (elem_count),
		.cfg        (cfg),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	rdrp_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cq_empty),
		.full    (cq_full)
	);

	rdrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!cq_empty),
		.cmd         (cmd_head),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.run_kind    (run_kind),
		.run_offset  (run_offset),
		.run_length  (run_length),
		.last_of_run (last_of_run)
	);

endmodule

FILE: sv/rdrp_checker.sv
// Port-level checks of the run planner, attached to the top level by bind.
// Depends on rdrp_pkg.
module rdrp_checker
	import rdrp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input logic [1:0]            run_kind,
	input logic [OFF_W-1:0]      run_offset,
	input logic [OFF_W-1:0]      run_length,
	input logic                  last_of_run,
	input logic                  cfg_ready
);

	// An error word has no length and closes its token.
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && run_kind == KIND_ERROR) |-> (run_length == '0 && last_of_run))
		else $error("error word with length or without last mark");

	// Copy runs are only planned for a nonzero count.
	a_copy_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && run_kind == KIND_COPY) |-> (run_length != '0))
		else $error("copy run of zero length");

	// A copy run that is not last is followed by its fill run right after it.
	a_copy_then_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && run_kind == KIND_COPY && !last_of_run) |=>
		(!empty && run_kind == KIND_FILL && run_offset == $past(run_offset) + $past(run_length)))
		else $error("padding run does not follow its copy run");

	// A waiting word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(run_kind) && $stable(run_offset)
		&& $stable(run_length) && $stable(last_of_run)))
		else $error("waiting result word changed");

	// The input side stays closed while the block sizes are rebuilt.
	a_full_in_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> full)
		else $error("input open during block size rebuild");

endmodule

bind ragged_to_dense_run_planner rdrp_checker u_rdrp_checker (.*);

FILE: bench/ragged_to_dense_run_planner_tb.sv
// Self-checking bench for the ragged-to-dense run planner: it drives nesting tokens and shape
// writes, predicts every run word from its own copy of the planner state and checks them in order.
// Depends on rdrp_pkg and on the ragged_to_dense_run_planner top level.
module ragged_to_dense_run_planner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdrp_pkg::*;

	localparam int LIMIT_CYCLES  = 500000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 960;
	localparam int RANDOM_PHASES = 8;
	localparam int OVER_PAIRS    = 40;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = REG_NUM_DIMS + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = REG_NUM_DIMS + 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = REG_NUM_DIMS + 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE      = REG_DIM_SIZE_3 + 3'd1;

	// Ports of the block.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            func = FUNC_BEGIN;
	logic [LEN_W-1:0]      elem_count = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [1:0]            run_kind;
	logic [OFF_W-1:0]      run_offset;
	logic [OFF_W-1:0]      run_length;
	logic                  last_of_run;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_DIMS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Planner state as the bench predicts it.
	logic [NDIM_W-1:0]     shape_dims;
	logic [LEN_W-1:0]      shape_len [MAX_DIMS];
	logic [OFF_W-1:0]      blk_size [MAX_DIMS+1];
	int                    cur_level;
	logic [CNT_W-1:0]      group_cnt [MAX_DIMS+1];
	logic [OFF_W-1:0]      row_base;
	bit                    err_latched;

	// Run words still due, oldest first.
	result_t               pending_runs [$];
	result_t               want;

	bit                    idle_on = 1'b1;
	int                    pop_hold = 0;
	int                    cycles = 0;
	int                    fails = 0;
	int                    live_items = 0;
	int                    tokens_sent = 0;
	int                    cfg_writes = 0;
	int                    runs_seen [3] = '{0, 0, 0};

	ragged_to_dense_run_planner dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.elem_count (elem_count),
		.empty      (empty),
		.pop        (pop),
		.run_kind   (run_kind),
		.run_offset (run_offset),
		.run_length (run_length),
		.last_of_run(last_of_run),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Dimension count as the planner sees it: zero counts as one, large values clamp.
	function automatic int used_dims();
		int n;
		n = int'(shape_dims);
		if (n < 1) n = 1;
		if (n > MAX_DIMS) n = MAX_DIMS;
		return n;
	endfunction

	// Elements per group at each level, innermost level last.
	function automatic void rebuild_blocks();
		int n;
		n = used_dims();
		for (int i = 0; i <= MAX_DIMS; i++) blk_size[i] = OFF_W'(1);
		for (int i = n; i > 0; i--) blk_size[i-1] = OFF_W'(shape_len[i-1]) * blk_size[i];
	endfunction

	function automatic void clear_record();
		cur_level = 0;
		for (int i = 0; i <= MAX_DIMS; i++) group_cnt[i] = '0;
		row_base = '0;
		err_latched = 1'b0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == REG_NUM_DIMS) begin
			shape_dims = data[NDIM_W-1:0];
		end else if (idx <= REG_DIM_SIZE_3) begin
			shape_len[int'(idx) - 1] = data;
		end else begin
			return;
		end
		rebuild_blocks();
	endfunction

	function automatic result_t make_run(logic [1:0] kind, logic [OFF_W-1:0] off,
			logic [OFF_W-1:0] len, bit last);
		result_t r;
		r.kind   = kind;
		r.offset = off;
		r.length = len;
		r.last   = last;
		return r;
	endfunction

	// Appends one word at the young end of the list of words due.
	function automatic void queue_run(result_t r);
		pending_runs.insert(pending_runs.size(), r);
	endfunction

	// An error gives one word at the current row and blocks all but restart.
	function automatic void flag_error();
		err_latched = 1'b1;
		queue_run(make_run(KIND_ERROR, row_base, '0, 1'b1));
	endfunction

	// Works out the run words caused by one token and advances the predicted state.
	function automatic void plan_token(logic [1:0] f, logic [LEN_W-1:0] c);
		int n;
		int lvl;
		logic [OFF_W-1:0] cnt;
		logic [OFF_W-1:0] length;
		logic [OFF_W-1:0] delta;
		bit has_fill;
		if (f == FUNC_RESTART) begin
			clear_record();
			return;
		end
		if (err_latched) return;
		n = used_dims();
		lvl = cur_level;
		if (f == FUNC_BEGIN) begin
			if (lvl >= n) begin
				flag_error();
			end else begin
				if (group_cnt[lvl] != COUNT_MAX) group_cnt[lvl]++;
				cur_level = lvl + 1;
			end
			return;
		end
		if (f == FUNC_COUNT) begin
			if (lvl != n) flag_error();
			else group_cnt[lvl] = CNT_W'(c);
			return;
		end
		// A finish must close a group that exists at a level in use.
		if (lvl == 0 || lvl > n) begin
			flag_error();
			return;
		end
		cnt = OFF_W'(group_cnt[lvl]);
		length = OFF_W'(shape_len[lvl-1]);
		if (lvl == n) begin
			if (cnt > length) begin
				flag_error();
				return;
			end
			has_fill = cnt < length;
			if (cnt != 0) queue_run(make_run(KIND_COPY, row_base, cnt, !has_fill));
			if (has_fill) begin
				queue_run(make_run(KIND_FILL, row_base + cnt, length - cnt, 1'b1));
			end
			row_base = row_base + length;
		end else if (cnt < length) begin
			delta = blk_size[lvl] * (length - cnt);
			queue_run(make_run(KIND_FILL, row_base, delta, 1'b1));
			row_base = row_base + delta;
		end
		group_cnt[lvl] = '0;
		cur_level = lvl - 1;
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		return LEN_W'($urandom());
	endfunction

	// Innermost count: mostly in range, with the edges, overflows and raw values mixed in.
	function automatic logic [LEN_W-1:0] pick_count(int len);
		int r;
		r = $urandom_range(0, 9);
		if (r == 6) return LEN_W'(len);
		if (r == 7) return '0;
		if (r == 8) return (len < 4095) ? LEN_W'(len + 1) : LEN_W'(4095);
		if (r == 9) return rand_len();
		return LEN_W'($urandom_range(0, len));
	endfunction

	// Subgroups in an outer group: small, sometimes one past the dimension length.
	function automatic int pick_groups(int len);
		if ($urandom_range(0, 9) == 0) return len + 1;
		return $urandom_range(0, (len < 3) ? len : 3);
	endfunction

	function automatic void check_field(string name, logic [OFF_W-1:0] want_v,
			logic [OFF_W-1:0] got_v);
		if (want_v !== got_v) begin
			fails++;
			$display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endfunction

	// Sends one token word, with a random gap before it while idling is on.
	task automatic send_token(input logic [1:0] f, input logic [LEN_W-1:0] c);
		if (idle_on && $urandom_range(0, 11) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		elem_count <= c;
		do @(posedge clk); while (full);
		if (f == FUNC_RESTART || !err_latched) live_items++;
		tokens_sent++;
		plan_token(f, c);
	endtask

	// Writes one register; valid stays high when another write follows at once.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (!more) cfg_valid <= 1'b0;
		cfg_writes++;
		apply_reg(idx, data);
	endtask

	// Holds the sender until every due word has arrived and the pipeline has gone quiet.
	task automatic settle();
		push <= 1'b0;
		while (pending_runs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_shape(input logic [NDIM_W-1:0] n, input int d0, input int d1,
			input int d2, input int d3);
		settle();
		cfg_write(REG_NUM_DIMS, {(CFG_DATA_W-NDIM_W)'($urandom()), n}, 1'b1);
		cfg_write(REG_DIM_SIZE_0, CFG_DATA_W'(d0), 1'b1);
		cfg_write(REG_DIM_SIZE_1, CFG_DATA_W'(d1), 1'b1);
		cfg_write(REG_DIM_SIZE_2, CFG_DATA_W'(d2), 1'b1);
		cfg_write(REG_DIM_SIZE_3, CFG_DATA_W'(d3), 1'b0);
	endtask

	// One record laid out in nesting order, with some stray tokens thrown in.
	task automatic run_record();
		int n;
		int l;
		int left [MAX_DIMS+1];
		n = used_dims();
		if (err_latched || $urandom_range(0, 7) == 0) send_token(FUNC_RESTART, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		l = 1;
		if (n > 1) left[1] = pick_groups(int'(shape_len[0]));
		while (l > 0) begin
			if ($urandom_range(0, 39) == 0) send_token(2'($urandom()), rand_len());
			if (l == n) begin
				if ($urandom_range(0, 9) != 0) begin
					send_token(FUNC_COUNT, pick_count(int'(shape_len[n-1])));
				end
				send_token(FUNC_FINISH, rand_len());
				l--;
			end else if (left[l] > 0) begin
				left[l]--;
				send_token(FUNC_BEGIN, rand_len());
				l++;
				if (l < n) left[l] = pick_groups(int'(shape_len[l-1]));
			end else begin
				send_token(FUNC_FINISH, rand_len());
				l--;
			end
		end
	endtask

	// Reset shape: one dimension of length one; copy, count too large, sticky error, restart.
	task automatic test_reset_shape();
		send_token(FUNC_BEGIN, 12'hFFF);
		send_token(FUNC_COUNT, 12'd1);
		send_token(FUNC_FINISH, 12'h000);
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_COUNT, 12'd2);
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_RESTART, 12'hABC);
	endtask

	// Zero dimensions count as one; innermost counts at both ends of the field.
	task automatic test_inner_extremes();
		set_shape(3'd0, 4095, 0, 4095, 0);
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_COUNT, 12'hFFF);
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_FINISH, rand_len());
	endtask

	// Finish at the top, a count above the innermost level, a begin at the innermost level.
	task automatic test_bad_nesting();
		set_shape(3'd2, 3, 2, 1, 1);
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_RESTART, rand_len());
		send_token(FUNC_COUNT, 12'd1);
		send_token(FUNC_RESTART, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_RESTART, rand_len());
	endtask

	// Short groups at every outer level pad by whole blocks.
	task automatic test_outer_fill();
		set_shape(3'd3, 3, 2, 4, 0);
		repeat (3) send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_COUNT, 12'd1);
		repeat (3) send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_RESTART, rand_len());
	endtask

	// Four full-size dimensions; two empty outer groups carry the offset past its top.
	task automatic test_offset_wrap();
		set_shape(3'd7, 4095, 4095, 4095, 4095);
		repeat (2) begin
			send_token(FUNC_BEGIN, rand_len());
			send_token(FUNC_FINISH, rand_len());
		end
		send_token(FUNC_RESTART, rand_len());
	endtask

	// Fewer dimensions written while a record is open leave it nested too deep.
	task automatic test_shape_change_in_record();
		set_shape(3'd4, 2, 2, 2, 2);
		repeat (3) send_token(FUNC_BEGIN, rand_len());
		settle();
		cfg_write(REG_SPARE + 3'($urandom_range(0, 2)), rand_len(), 1'b1);
		cfg_write(REG_NUM_DIMS, {(CFG_DATA_W-NDIM_W)'($urandom()), 3'd2}, 1'b0);
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_RESTART, rand_len());
	endtask

	// An outer group with more subgroups than its length gives no padding and keeps the row.
	task automatic test_outer_overcount();
		set_shape(3'd2, 30, 0, $urandom_range(0, 4095), $urandom_range(0, 4095));
		idle_on = 1'b0;
		send_token(FUNC_RESTART, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		repeat (OVER_PAIRS) begin
			send_token(FUNC_BEGIN, rand_len());
			send_token(FUNC_FINISH, rand_len());
		end
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_BEGIN, rand_len());
		send_token(FUNC_FINISH, rand_len());
		send_token(FUNC_RESTART, rand_len());
		idle_on = 1'b1;
	endtask

	// Random records over a spread of shapes; the last phases run without idling.
	task automatic test_random_records();
		int target;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: set_shape(3'd1, 4095, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095));
				1: set_shape(3'd2, 3, 200, $urandom_range(0, 4095), $urandom_range(0, 4095));
				2: set_shape(3'd3, 3, 2, 9, $urandom_range(0, 4095));
				3: set_shape(3'd4, 2, 2, 3, 4);
				4: set_shape(3'd0, 17, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
				5: set_shape(NDIM_W'($urandom_range(5, 7)), $urandom_range(0, 3),
					$urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
				6: set_shape(3'd2, 0, 5, $urandom_range(0, 4095), $urandom_range(0, 4095));
				default: set_shape(3'd3, $urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4), $urandom_range(0, 4095));
			endcase
			idle_on = (p < RANDOM_PHASES - 2);
			target = live_items + RANDOM_ITEMS / RANDOM_PHASES;
			while (live_items < target) run_record();
		end
	endtask

	// Result side stalls in random bursts while idling is on.
	always @(posedge clk) begin
		if (pop_hold != 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			pop_hold = $urandom_range(0, 9);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Every accepted run word is compared with the oldest one due.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_runs.size() == 0) begin
				fails++;
				$display("%0t ns: run word with none due: kind %0d offset %0d length %0d last %0b",
					$time, run_kind, run_offset, run_length, last_of_run);
			end else begin
				want = pending_runs.pop_front();
				check_field("run_kind", OFF_W'(want.kind), OFF_W'(run_kind));
				check_field("run_offset", want.offset, run_offset);
				check_field("run_length", want.length, run_length);
				check_field("last_of_run", OFF_W'(want.last), OFF_W'(last_of_run));
				runs_seen[want.kind]++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles with %0d run words still due",
				cycles, pending_runs.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Reset, the directed tests, the random records, then the verdict.
	initial begin
		shape_dims = NDIM_W'(1);
		for (int i = 0; i < MAX_DIMS; i++) shape_len[i] = LEN_W'(1);
		clear_record();
		rebuild_blocks();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_shape();
		test_inner_extremes();
		test_bad_nesting();
		test_outer_fill();
		test_offset_wrap();
		test_shape_change_in_record();
		test_outer_overcount();
		test_random_records();
		settle();

		$display("Sent %0d tokens (%0d not ignored) over %0d register writes.",
			tokens_sent, live_items, cfg_writes);
		$display("Checked %0d copy, %0d fill and %0d error words; %0d mismatches.",
			runs_seen[KIND_COPY], runs_seen[KIND_FILL], runs_seen[KIND_ERROR], fails);
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: ragged_to_dense_run_planner.f
sv/rdrp_pkg.sv
sv/rdrp_config.sv
sv/rdrp_front.sv
sv/rdrp_cmd_queue.sv
sv/rdrp_back.sv
sv/ragged_to_dense_run_planner.sv
sv/rdrp_checker.sv
bench/ragged_to_dense_run_planner_tb.sv
